// ===== hw/rtl/path_vertex_table_lerp_unit_macros.svh =====
// ----------------------------------------------------------------------------
// path_vertex_table_lerp_unit_macros
// Assertion macros for the path vertex table unit.
// ----------------------------------------------------------------------------
`ifndef PATH_VERTEX_TABLE_LERP_UNIT_MACROS_SVH
`define PATH_VERTEX_TABLE_LERP_UNIT_MACROS_SVH
// check that an antecedent implies a consequence in the same cycle
`define PVT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// check that an antecedent implies a consequence in the following cycle
`define PVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/pvt_pkg.sv =====
// ----------------------------------------------------------------------------
// pvt_pkg
// Shared types and codes for the path vertex table unit.
// ----------------------------------------------------------------------------
package pvt_pkg;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    // coordinates are Q16.16; interpolation does not depend on the split
    localparam int COORD_FRAC_BITS = 16;
    localparam int SEG_FRAC_BITS   = 16;
    localparam int DIV_STEPS       = 64 + SEG_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DIV,
        S_RD_A,
        S_RD_B,
        S_MUL,
        S_LERP,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic append_wr;
        logic shift_rd;
        logic shift_wr;
        logic div_start;
        logic div_step;
        logic rd_a;
        logic rd_b;
        logic mul;
        logic lerp;
        logic clear;
        logic dec_count;
        logic set_status;
        logic [1:0] status;
        logic sel_read;
        logic sel_zero;
        logic sel_a;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic slot_ok;
        logic query_bad;
        logic shift_last;
        logic div_last;
        logic at_end;
        logic [2:0] op;
    } stat_t;

endpackage

// ===== hw/rtl/pvt_stream_if.sv =====
// ----------------------------------------------------------------------------
// pvt_stream_if
// Valid/ready channel carrying a payload of parameter width.
// ----------------------------------------------------------------------------
interface pvt_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pvt_ctrl
// Sequencer for table operations, removal shifts, division and interpolation.
// ----------------------------------------------------------------------------
module pvt_ctrl
    import pvt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  out_fire,
    input  stat_t stat,
    output logic  in_ready,
    output logic  out_valid,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_fire) state_next = S_DECODE;
            S_DECODE:
            begin
                state_next = S_DONE;
                if (stat.op == OP_REMOVE && stat.slot_ok)
                    state_next = stat.shift_last ? S_DONE : S_SHIFT_RD;
                else if (stat.op == OP_QUERY && !stat.query_bad)
                    state_next = S_DIV;
            end
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: state_next = stat.shift_last ? S_DONE : S_SHIFT_RD;
            S_DIV:    if (stat.div_last) state_next = S_RD_A;
            S_RD_A:   state_next = S_RD_B;
            S_RD_B:   state_next = S_MUL;
            S_MUL:    state_next = S_LERP;
            S_LERP:   state_next = S_DONE;
            S_DONE:   if (out_fire) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            S_DECODE:
            begin
                cmd.set_status = 1'b1;
                cmd.sel_zero   = 1'b1;
                cmd.status     = ST_OK;
                case (stat.op)
                    OP_APPEND:
                    begin
                        if (stat.full)
                            cmd.status = ST_FULL;
                        else
                            cmd.append_wr = 1'b1;
                    end
                    OP_REMOVE:
                    begin
                        if (!stat.slot_ok)
                            cmd.status = ST_ABSENT;
                        else if (stat.shift_last)
                            cmd.dec_count = 1'b1;
                    end
                    OP_CLEAR: cmd.clear = 1'b1;
                    OP_READ:
                    begin
                        if (!stat.slot_ok)
                            cmd.status = ST_ABSENT;
                        else
                        begin
                            cmd.sel_zero = 1'b0;
                            cmd.sel_read = 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (stat.query_bad)
                            cmd.status = ST_OUTSIDE;
                        else
                            cmd.div_start = 1'b1;
                    end
                    default: cmd.status = ST_OK;
                endcase
            end
            S_SHIFT_RD: cmd.shift_rd = 1'b1;
            S_SHIFT_WR:
            begin
                cmd.shift_wr  = 1'b1;
                cmd.dec_count = stat.shift_last;
            end
            S_DIV:    cmd.div_step = 1'b1;
            S_RD_A:   cmd.rd_a = 1'b1;
            S_RD_B:   cmd.rd_b = 1'b1;
            S_MUL:    cmd.mul = 1'b1;
            S_LERP:
            begin
                cmd.lerp  = 1'b1;
                cmd.sel_a = stat.at_end;
            end
            S_DONE:   out_valid = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/pvt_datapath.sv =====
// ----------------------------------------------------------------------------
// pvt_datapath
// Vertex memory, count, restoring divider and interpolation multipliers.
// ----------------------------------------------------------------------------
module pvt_datapath
    import pvt_pkg::*;
#(
    parameter int MAX_VERTICES    = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [2:0]  op_in,
    input  logic [31:0] x_in,
    input  logic [31:0] y_in,
    input  logic [31:0] z_in,
    input  logic [$clog2(MAX_VERTICES)-1:0] slot_in,
    input  logic [31:0] time_in,
    input  logic [31:0] duration,
    output logic [31:0] res_x,
    output logic [31:0] res_y,
    output logic [31:0] res_z,
    output logic [1:0]  res_status,
    output logic [$clog2(MAX_VERTICES+1)-1:0] res_count
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = $clog2(DIV_STEPS + 1);
    localparam int VW = 3 * 32;

    logic [VW-1:0] mem [MAX_VERTICES];
    logic [VW-1:0] rd_reg;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    logic [2:0]    op_reg;
    logic [95:0]   vin_reg;
    logic [AW-1:0] slot_reg;
    logic [31:0]   time_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] ptr_reg;
    logic [31:0]   rx_reg, ry_reg, rz_reg;
    logic [1:0]    st_reg;

    // divider: dividend {scaled, 16 zero bits}, quotient idx.frac
    logic [95:0]   dvd_reg;
    logic [31:0]   rem_reg;
    logic [SW-1:0] step_reg;
    logic [AW-1:0] idx_reg;
    logic [SEG_FRAC_BITS:0] frac_reg;
    logic          end_reg;
    logic [VW-1:0] va_reg;
    logic signed [32+SEG_FRAC_BITS+2:0] prod_reg [3];

    logic [CW-1:0] last_idx;
    logic [63:0]   scaled;
    logic [32:0]   rem_sh;
    logic [32:0]   rem_sub;
    logic [DIV_STEPS-1:0] quo_full;
    logic [63:0]   seg_q;
    logic          seg_end;
    logic [AW-1:0] seg_idx;

    assign last_idx = count_reg - CW'(1);
    assign scaled   = 64'(time_reg) * 64'(last_idx);
    assign rem_sh   = {rem_reg, dvd_reg[95]};
    assign rem_sub  = rem_sh - {1'b0, duration};

    // segment index from the finished quotient; clamp at the last table slot
    assign seg_q = quo_full[SEG_FRAC_BITS +: 64];

    always_comb
    begin
        seg_end = (seg_q >= 64'(last_idx)) || (seg_q + 64'd1 >= 64'(MAX_VERTICES));
        seg_idx = (seg_q >= 64'(MAX_VERTICES)) ? AW'(MAX_VERTICES - 1) : seg_q[AW-1:0];
    end

    // memory port
    always_comb
    begin
        rd_en   = cmd.shift_rd || cmd.rd_a || cmd.rd_b || cmd.load;
        rd_addr = ptr_reg;
        if (cmd.load)
            rd_addr = slot_in;
        else if (cmd.shift_rd)
            rd_addr = AW'(ptr_reg + AW'(1));
        else if (cmd.rd_a)
            rd_addr = seg_idx;
        else if (cmd.rd_b && !end_reg)
            rd_addr = AW'(idx_reg + AW'(1));
        else if (cmd.rd_b)
            rd_addr = idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_reg <= mem[rd_addr];
        if (cmd.append_wr)
            mem[count_reg[AW-1:0]] <= vin_reg;
        else if (cmd.shift_wr)
            mem[ptr_reg] <= rd_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            if (cmd.append_wr)
                count_reg <= count_reg + CW'(1);
            else if (cmd.clear)
                count_reg <= '0;
            else if (cmd.dec_count)
                count_reg <= count_reg - CW'(1);
            if (cmd.div_start)
                step_reg <= SW'(DIV_STEPS - 1);
            else if (cmd.div_step && step_reg != '0)
                step_reg <= step_reg - SW'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_in;
            vin_reg  <= {z_in, y_in, x_in};
            slot_reg <= slot_in;
            time_reg <= time_in;
            ptr_reg  <= slot_in;
        end
        if (cmd.shift_wr)
            ptr_reg <= ptr_reg + AW'(1);
        if (cmd.set_status)
        begin
            st_reg <= cmd.status;
            rx_reg <= '0;
            ry_reg <= '0;
            rz_reg <= '0;
            if (cmd.sel_read)
            begin
                rx_reg <= rd_reg[31:0];
                ry_reg <= rd_reg[63:32];
                rz_reg <= rd_reg[95:64];
            end
        end
        // restoring division, one quotient bit a cycle
        if (cmd.div_start)
        begin
            dvd_reg  <= {scaled, 32'd0};
            rem_reg  <= '0;
            quo_full <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[94:0], 1'b0};
            if (!rem_sub[32])
            begin
                rem_reg  <= rem_sub[31:0];
                quo_full <= {quo_full[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[31:0];
                quo_full <= {quo_full[DIV_STEPS-2:0], 1'b0};
            end
        end
        if (cmd.rd_a)
        begin
            // quotient holds idx in upper bits, frac in low SEG_FRAC_BITS
            frac_reg <= {1'b0, quo_full[SEG_FRAC_BITS-1:0]};
            end_reg  <= seg_end;
            idx_reg  <= seg_idx;
        end
        if (cmd.rd_b)
            va_reg <= rd_reg;
        if (cmd.mul)
        begin
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= (34'(signed'(rd_reg[32*k +: 32]))
                               - 34'(signed'(va_reg[32*k +: 32])))
                               * signed'(frac_reg);
        end
        if (cmd.lerp)
        begin
            st_reg <= ST_OK;
            if (cmd.sel_a)
            begin
                rx_reg <= va_reg[31:0];
                ry_reg <= va_reg[63:32];
                rz_reg <= va_reg[95:64];
            end
            else
            begin
                rx_reg <= va_reg[31:0]  + 32'(prod_reg[0] >>> SEG_FRAC_BITS);
                ry_reg <= va_reg[63:32] + 32'(prod_reg[1] >>> SEG_FRAC_BITS);
                rz_reg <= va_reg[95:64] + 32'(prod_reg[2] >>> SEG_FRAC_BITS);
            end
        end
    end

    logic [AW:0] next_ptr;
    assign next_ptr = {1'b0, ptr_reg} + (AW+1)'(1);

    always_comb
    begin
        stat.op         = op_reg;
        stat.full       = count_reg >= CW'(MAX_VERTICES);
        stat.slot_ok    = CW'(slot_reg) < count_reg;
        stat.query_bad  = duration == '0 || count_reg == '0 || time_reg > duration;
        stat.shift_last = CW'(next_ptr) >= count_reg;
        stat.div_last   = step_reg == '0;
        stat.at_end     = end_reg;
    end

    assign res_x      = rx_reg;
    assign res_y      = ry_reg;
    assign res_z      = rz_reg;
    assign res_status = st_reg;
    assign res_count  = count_reg;

endmodule

// ===== hw/rtl/path_vertex_table_lerp_unit.sv =====
// Steps from accept to result: append, clear, read, a rejected item and unknown codes
// only decode; remove moves each entry above the slot down by a read and a write; query
// divides one bit a cycle over 80 quotient bits, then reads, multiplies, interpolates.
// Throughput: one item at a time; the next is taken once the result transfers.
// Reset: asynchronous, active low; clears vertex count and duration. The vertex
// memory has no reset, entries are only used below the count.
// ----------------------------------------------------------------------------
// path_vertex_table_lerp_unit
// Ordered vertex table with piecewise linear position query.
// ----------------------------------------------------------------------------
`include "path_vertex_table_lerp_unit_macros.svh"

module path_vertex_table_lerp_unit
    import pvt_pkg::*;
#(
    parameter int MAX_VERTICES    = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [31:0] in_x,
    input  logic [31:0] in_y,
    input  logic [31:0] in_z,
    input  logic [$clog2(MAX_VERTICES)-1:0] slot,
    input  logic [31:0] query_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [1:0]  status,
    output logic [$clog2(MAX_VERTICES+1)-1:0] vertex_count
);

    logic [31:0] duration_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // hold duration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duration_reg <= '0;
        else if (cfg_we)
            duration_reg <= cfg_wdata;
    end

    pvt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .stat(stat), .in_ready(in_ready), .out_valid(out_valid), .cmd(cmd)
    );

    pvt_datapath #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .op_in(operation), .x_in(in_x), .y_in(in_y), .z_in(in_z),
        .slot_in(slot), .time_in(query_time), .duration(duration_reg),
        .res_x(out_x), .res_y(out_y), .res_z(out_z),
        .res_status(status), .res_count(vertex_count)
    );

    // checks
    `PVT_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready, "ready while result pending")
    `PVT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(out_x), "result dropped")
    `PVT_ASSERT_IMP(a_cnt, clk, rst_n, 1'b1, vertex_count <= MAX_VERTICES, "count overflow")

endmodule

// ===== tb/tb_path_vertex_table_lerp_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_path_vertex_table_lerp_unit
// Drives append, remove, clear, read and query commands into the path vertex
// table through a valid/ready channel. A local model of the table predicts
// each result, and the monitor compares every returned transfer field by
// field. Duration is changed between phases only while the unit is idle.
// Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_path_vertex_table_lerp_unit;
    import pvt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [5:0]  slot;
        logic [31:0] qtime;
    } path_cmd_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [1:0]  status;
        logic [6:0]  count;
    } path_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    pvt_stream_if #(.payload_t(path_cmd_t)) cmd_ch ();
    pvt_stream_if #(.payload_t(path_res_t)) res_ch ();

    // table copy held by the predictor
    logic [31:0] tbl_x [TABLE_DEPTH];
    logic [31:0] tbl_y [TABLE_DEPTH];
    logic [31:0] tbl_z [TABLE_DEPTH];
    int unsigned tbl_count;
    logic [31:0] duration;

    path_cmd_t   pending_cmds [$];
    path_res_t   expected_res [$];
    int          error_count;
    int          idle_max;
    int          gap_left;
    int          stall_left;
    int          hold_left;
    int          hold_token;
    int          hold_seen;
    int          quiet_cycles;
    logic        cmd_fired;
    logic        res_fired;

    path_vertex_table_lerp_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (cmd_ch.valid),
        .in_ready     (cmd_ch.ready),
        .operation    (cmd_ch.data.operation),
        .in_x         (cmd_ch.data.x),
        .in_y         (cmd_ch.data.y),
        .in_z         (cmd_ch.data.z),
        .slot         (cmd_ch.data.slot),
        .query_time   (cmd_ch.data.qtime),
        .out_valid    (res_ch.valid),
        .out_ready    (res_ch.ready),
        .out_x        (res_ch.data.x),
        .out_y        (res_ch.data.y),
        .out_z        (res_ch.data.z),
        .status       (res_ch.data.status),
        .vertex_count (res_ch.data.count)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // interpolate one coordinate, rounding the step towards minus infinity
    function automatic logic [31:0] lerp_axis(logic [31:0] a, logic [31:0] b,
                                              longint unsigned frac);
        longint start_v;
        longint prod;
        start_v = longint'(signed'(a));
        prod = (longint'(signed'(b)) - start_v) * longint'(frac);
        return 32'(start_v + (prod >>> SEG_FRAC_BITS));
    endfunction

    // apply one command to the table copy and return the result it gives
    function automatic path_res_t apply_path_cmd(path_cmd_t c);
        path_res_t       r;
        longint unsigned scaled;
        longint unsigned seg;
        longint unsigned rem;
        longint unsigned frac;
        r = '0;
        r.status = ST_OK;
        case (c.operation)
            OP_APPEND:
            begin
                if (tbl_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    tbl_x[tbl_count] = c.x;
                    tbl_y[tbl_count] = c.y;
                    tbl_z[tbl_count] = c.z;
                    tbl_count++;
                end
            end
            OP_REMOVE:
            begin
                if (c.slot < tbl_count)
                begin
                    for (int i = c.slot; i + 1 < tbl_count; i++)
                    begin
                        tbl_x[i] = tbl_x[i + 1];
                        tbl_y[i] = tbl_y[i + 1];
                        tbl_z[i] = tbl_z[i + 1];
                    end
                    tbl_count--;
                end
                else
                    r.status = ST_ABSENT;
            end
            OP_CLEAR:
                tbl_count = 0;
            OP_READ:
            begin
                if (c.slot < tbl_count)
                begin
                    r.x = tbl_x[c.slot];
                    r.y = tbl_y[c.slot];
                    r.z = tbl_z[c.slot];
                end
                else
                    r.status = ST_ABSENT;
            end
            OP_QUERY:
            begin
                if (duration == 0 || tbl_count == 0 || c.qtime > duration)
                    r.status = ST_OUTSIDE;
                else
                begin
                    scaled = longint'(c.qtime) * longint'(tbl_count - 1);
                    seg = scaled / duration;
                    rem = scaled % duration;
                    frac = (rem << SEG_FRAC_BITS) / duration;
                    if (seg >= tbl_count - 1)
                    begin
                        r.x = tbl_x[seg];
                        r.y = tbl_y[seg];
                        r.z = tbl_z[seg];
                    end
                    else
                    begin
                        r.x = lerp_axis(tbl_x[seg], tbl_x[seg + 1], frac);
                        r.y = lerp_axis(tbl_y[seg], tbl_y[seg + 1], frac);
                        r.z = lerp_axis(tbl_z[seg], tbl_z[seg + 1], frac);
                    end
                end
            end
            default:
                ;
        endcase
        r.count = 7'(tbl_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // append a command to the pending queue
    task automatic queue_cmd(path_cmd_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // driver: offer pending commands at the falling edge, with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && !cmd_fired)
                ;
            else if (gap_left > 0)
            begin
                cmd_ch.valid <= 1'b0;
                gap_left--;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd_ch.data  <= pending_cmds.pop_front();
                cmd_ch.valid <= 1'b1;
                gap_left = $urandom_range(0, idle_max);
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold when requested
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = 300;
            end
            if (res_fired)
                stall_left = $urandom_range(0, idle_max);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // monitor: predict on accepted commands, check accepted results
    always @(posedge clk)
    begin
        path_res_t want;
        path_res_t got;
        path_res_t pred;
        if (rst_n)
        begin
            cmd_fired <= cmd_ch.valid && cmd_ch.ready;
            res_fired <= res_ch.valid && res_ch.ready;
            if (cfg_we)
                duration = cfg_wdata;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                pred = apply_path_cmd(cmd_ch.data);
                expected_res = {expected_res, pred};
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.data;
                if (expected_res.size() == 0)
                    report_mismatch("unexpected result transfer", 32'd0, 32'd0);
                else
                begin
                    want = expected_res.pop_front();
                    if (got.x !== want.x)
                        report_mismatch("out_x", got.x, want.x);
                    if (got.y !== want.y)
                        report_mismatch("out_y", got.y, want.y);
                    if (got.z !== want.z)
                        report_mismatch("out_z", got.z, want.z);
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.count !== want.count)
                        report_mismatch("vertex_count", 32'(got.count), 32'(want.count));
                end
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
                || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("path_vertex_table_lerp_unit test failed");
            $finish;
        end
    end

    function automatic path_cmd_t make_cmd(logic [2:0] op, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z,
                                           logic [5:0] s, logic [31:0] t);
        path_cmd_t c;
        c.operation = op;
        c.x = x;
        c.y = y;
        c.z = z;
        c.slot = s;
        c.qtime = t;
        return c;
    endfunction

    // random command; append_bias in percent steers the table towards full
    function automatic path_cmd_t random_cmd(int append_bias, logic [31:0] dur);
        path_cmd_t c;
        int        pick;
        int        tsel;
        c = make_cmd(OP_APPEND, $urandom, $urandom, $urandom,
                     6'($urandom_range(0, 63)), $urandom);
        if ($urandom_range(0, 1))
            c.slot = 6'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < append_bias)
            c.operation = OP_APPEND;
        else if (pick < append_bias + 10)
            c.operation = OP_REMOVE;
        else if (pick < append_bias + 12)
            c.operation = OP_CLEAR;
        else if (pick < append_bias + 27)
            c.operation = OP_READ;
        else if (pick < 98)
            c.operation = OP_QUERY;
        else
            c.operation = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 3) == 0)
        begin
            // small coordinates so that interpolation steps are visible
            c.x = 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
            c.y = 32'($signed($urandom_range(0, 2000)) - 1000) <<< 8;
        end
        tsel = $urandom_range(0, 9);
        if (dur != 0 && tsel < 7)
            c.qtime = 32'((longint'($urandom) * (longint'(dur) + 1)) >> 32);
        else if (tsel == 7)
            c.qtime = dur;
        else if (tsel == 8)
            c.qtime = 32'(dur + 1);
        return c;
    endfunction

    // wait for the unit to drain, then write the duration
    task automatic set_duration(logic [31:0] v);
        wait (pending_cmds.size() == 0 && !cmd_ch.valid && expected_res.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(int n, int append_bias, logic [31:0] dur);
        for (int i = 0; i < n; i++)
            queue_cmd(random_cmd(append_bias, dur));
    endtask

    initial
    begin
        logic [31:0] dur;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
        tbl_count    = 0;
        duration     = '0;
        error_count  = 0;
        idle_max     = 15;
        gap_left     = 0;
        stall_left   = 0;
        hold_left    = 0;
        hold_token   = 0;
        hold_seen    = 0;
        quiet_cycles = 0;
        cmd_fired    = 1'b0;
        res_fired    = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, zero duration, extreme coordinates
        queue_cmd(make_cmd(OP_QUERY, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_REMOVE, 0, 0, 0, 63, 0));
        queue_cmd(make_cmd(OP_APPEND, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0));
        queue_cmd(make_cmd(OP_QUERY, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_APPEND, 32'h7fff_ffff, 32'h8000_0000,
                           32'hffff_ffff, 0, 0));
        queue_cmd(make_cmd(OP_READ, 0, 0, 0, 1, 0));
        queue_cmd(make_cmd(OP_READ, 0, 0, 0, 2, 0));
        queue_cmd(make_cmd(3'd5, 1, 2, 3, 0, 0));
        queue_cmd(make_cmd(3'd6, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(3'd7, 0, 0, 0, 0, 0));
        set_duration(32'hffff_ffff);
        // directed: queries at the ends and middle of the longest path
        queue_cmd(make_cmd(OP_QUERY, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_QUERY, 0, 0, 0, 0, 32'hffff_ffff));
        queue_cmd(make_cmd(OP_QUERY, 0, 0, 0, 0, 32'h8000_0000));
        queue_cmd(make_cmd(OP_REMOVE, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_QUERY, 0, 0, 0, 0, 32'h1234_5678));
        set_duration(32'd1);
        // directed: single vertex, unit duration, time beyond it
        queue_cmd(make_cmd(OP_QUERY, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_QUERY, 0, 0, 0, 0, 1));
        queue_cmd(make_cmd(OP_QUERY, 0, 0, 0, 0, 2));
        queue_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_QUERY, 0, 0, 0, 0, 0));

        // fill past the limit, then random traffic
        dur = $urandom;
        set_duration(dur);
        random_phase(90, 85, dur);
        random_phase(210, 35, dur);
        hold_token++;
        random_phase(100, 35, dur);

        idle_max = 0;
        dur = $urandom_range(1, 100);
        set_duration(dur);
        random_phase(300, 40, dur);

        idle_max = 15;
        set_duration(32'hffff_ffff);
        random_phase(80, 90, 32'hffff_ffff);
        random_phase(220, 30, 32'hffff_ffff);

        set_duration(32'd0);
        random_phase(150, 40, 32'd0);

        idle_max = 3;
        set_duration(32'd1);
        random_phase(150, 40, 32'd1);

        idle_max = 15;
        dur = $urandom_range(1000, 1000000);
        set_duration(dur);
        random_phase(250, 40, dur);

        // drain, allow late transfers to appear, then report
        wait (pending_cmds.size() == 0 && !cmd_ch.valid && expected_res.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("path_vertex_table_lerp_unit test passed");
        else
            $display("path_vertex_table_lerp_unit test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pvt_pkg.sv
hw/rtl/pvt_stream_if.sv
hw/rtl/pvt_ctrl.sv
hw/rtl/pvt_datapath.sv
hw/rtl/path_vertex_table_lerp_unit.sv
tb/tb_path_vertex_table_lerp_unit.sv
